// ===== hw/rtl/spmq_pkg.sv =====
package spmq_pkg;

	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_POP  = 2'd1,
		CMD_MOVE = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEVEL = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	localparam int CMD_W    = 2;
	localparam int LEVEL_W  = 3;
	localparam int STATUS_W = 3;
	localparam int OUT_ID_W = 16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_POP_RD,
		S_POP_WAIT,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_APPEND,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch_in;
		logic pop_sel;
		logic pop_rd;
		logic pop_done;
		logic srch_start;
		logic srch_rd;
		logic srch_step;
		logic shift_rd;
		logic shift_wr;
		logic shift_done;
		logic append;
		logic set_status;
		status_t status;
		logic resp_valid;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic lvl_valid;
		logic tgt_full;
		logic any_nonempty;
		logic match;
		logic srch_skip;   // current level has no entry left to compare
		logic srch_end;
		logic shift_last;  // found entry is the newest of its level
		logic shift_tail;  // copy in progress is the last one of the gap
		logic out_ready;
	} stat_t;

endpackage

// ===== hw/rtl/spmq_if.sv =====
interface spmq_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/strict_priority_multilevel_queue.sv =====
// Strict-priority queue of entry IDs over LEVELS FIFO levels.
// Channel "in" carries command, entry_id and level; channel "out" carries
// status, out_id and out_level. Exactly one result per command.
// Add (command 0) appends an ID to its level; pop (command 1) returns the
// oldest ID of the highest non-empty level; move (command 2) searches
// levels from 1 up, oldest first, removes the first match, closes the gap
// and appends the ID to the target level.
// From accept to result valid an add passes the decide and append states,
// a pop decide, store read and read wait; an invalid level, full level,
// empty queue or no-op goes from decide to the result. A move takes a store
// read and a compare per entry scanned, a read alone per level skipped, and
// a read and a write per entry shifted; the single read port sets this.
// One command is in flight at a time; the next is taken the cycle after the
// result transfer.
// Reset clears all heads and counts; the entry store is not cleared and no
// clearing pass is needed. While the receiver stalls the result is held and
// no new command is taken.
module strict_priority_multilevel_queue #(
	parameter int DEPTH    = 128,
	parameter int LEVELS   = 5,
	parameter int ID_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	spmq_if.sink   in,
	spmq_if.source out
);
	spmq_pkg::ctrl_t ct;
	spmq_pkg::stat_t st, st_dp;

	always_comb begin
		st = st_dp;
		st.out_ready = out.ready;
	end

	spmq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
		.st(st), .ct(ct)
	);

	spmq_dp #(.DEPTH(DEPTH), .LEVELS(LEVELS), .ID_WIDTH(ID_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_command(in.data[20:19]), .in_entry_id(in.data[18:3]),
		.in_level(in.data[2:0]), .ct(ct), .st(st_dp),
		.status(out.data[21:19]), .out_id(out.data[18:3]), .out_level(out.data[2:0])
	);

	assign out.valid = ct.resp_valid;
endmodule

// ===== hw/rtl/spmq_ram.sv =====
module spmq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 640
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/spmq_ctrl.sv =====
module spmq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  spmq_pkg::stat_t    st,
	output spmq_pkg::ctrl_t    ct
);
	spmq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= spmq_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spmq_pkg::S_IDLE: if (in_valid) state_d = spmq_pkg::S_DECIDE;
			spmq_pkg::S_DECIDE: begin
				unique case (st.cmd)
					spmq_pkg::CMD_ADD:
						state_d = (st.lvl_valid && !st.tgt_full) ? spmq_pkg::S_APPEND
							: spmq_pkg::S_RESP;
					spmq_pkg::CMD_POP:
						state_d = st.any_nonempty ? spmq_pkg::S_POP_RD : spmq_pkg::S_RESP;
					spmq_pkg::CMD_MOVE:
						state_d = st.lvl_valid ? spmq_pkg::S_SRCH_RD : spmq_pkg::S_RESP;
					default: state_d = spmq_pkg::S_RESP;
				endcase
			end
			spmq_pkg::S_POP_RD:   state_d = spmq_pkg::S_POP_WAIT;
			spmq_pkg::S_POP_WAIT: state_d = spmq_pkg::S_RESP;
			// an exhausted level is skipped without a compare
			spmq_pkg::S_SRCH_RD:
				state_d = st.srch_end ? spmq_pkg::S_RESP
					: st.srch_skip ? spmq_pkg::S_SRCH_RD : spmq_pkg::S_SRCH_CMP;
			spmq_pkg::S_SRCH_CMP: begin
				priority if (st.match && st.tgt_full) state_d = spmq_pkg::S_RESP;
				else if (st.match) state_d = st.shift_last ? spmq_pkg::S_APPEND
					: spmq_pkg::S_SHIFT_RD;
				else state_d = spmq_pkg::S_SRCH_RD;
			end
			spmq_pkg::S_SHIFT_RD: state_d = spmq_pkg::S_SHIFT_WR;
			spmq_pkg::S_SHIFT_WR:
				state_d = st.shift_tail ? spmq_pkg::S_APPEND : spmq_pkg::S_SHIFT_RD;
			spmq_pkg::S_APPEND: state_d = spmq_pkg::S_RESP;
			spmq_pkg::S_RESP: if (st.out_ready) state_d = spmq_pkg::S_IDLE;
			default: state_d = spmq_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ct = '0;
		ct.status = spmq_pkg::ST_OK;
		in_ready = (state_q == spmq_pkg::S_IDLE);
		ct.latch_in = in_ready && in_valid;
		unique case (state_q)
			spmq_pkg::S_DECIDE: begin
				ct.set_status = 1'b1;
				unique case (st.cmd)
					spmq_pkg::CMD_ADD: ct.status = !st.lvl_valid ? spmq_pkg::ST_BAD_LEVEL
						: st.tgt_full ? spmq_pkg::ST_FULL : spmq_pkg::ST_OK;
					spmq_pkg::CMD_POP: begin
						ct.status = st.any_nonempty ? spmq_pkg::ST_OK : spmq_pkg::ST_EMPTY;
						ct.pop_sel = st.any_nonempty;
					end
					spmq_pkg::CMD_MOVE: begin
						ct.status = st.lvl_valid ? spmq_pkg::ST_NOT_FOUND
							: spmq_pkg::ST_BAD_LEVEL;
						ct.srch_start = st.lvl_valid;
					end
					default: ct.status = spmq_pkg::ST_OK;
				endcase
			end
			spmq_pkg::S_POP_RD:   ct.pop_rd = 1'b1;
			spmq_pkg::S_POP_WAIT: ct.pop_done = 1'b1;
			spmq_pkg::S_SRCH_RD:  ct.srch_rd = !st.srch_end;
			spmq_pkg::S_SRCH_CMP: begin
				ct.srch_step = !st.match;
				if (st.match) begin
					ct.set_status = 1'b1;
					ct.status = st.tgt_full ? spmq_pkg::ST_FULL : spmq_pkg::ST_OK;
					ct.shift_done = !st.tgt_full && st.shift_last;
				end
			end
			spmq_pkg::S_SHIFT_RD: ct.shift_rd = 1'b1;
			spmq_pkg::S_SHIFT_WR: begin
				ct.shift_wr = 1'b1;
				ct.shift_done = st.shift_tail;
			end
			spmq_pkg::S_APPEND: ct.append = 1'b1;
			spmq_pkg::S_RESP:   ct.resp_valid = 1'b1;
			default: ;
		endcase
	end

	// a response is only shown while no item is being taken
	a_resp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ct.resp_valid |-> !in_ready) else $error("response while idle");
	// an accepted item always leads to a decision
	a_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == spmq_pkg::S_DECIDE)
		else $error("accept did not decide");
	// a stalled response holds its state
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ct.resp_valid && !st.out_ready) |=> state_q == spmq_pkg::S_RESP)
		else $error("response dropped");
endmodule

// ===== hw/rtl/spmq_dp.sv =====
module spmq_dp #(
	parameter int DEPTH    = 128,
	parameter int LEVELS   = 5,
	parameter int ID_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [spmq_pkg::CMD_W-1:0]  in_command,
	input  logic [15:0]                 in_entry_id,
	input  logic [spmq_pkg::LEVEL_W-1:0] in_level,
	input  spmq_pkg::ctrl_t             ct,
	output spmq_pkg::stat_t             st,
	output logic [spmq_pkg::STATUS_W-1:0] status,
	output logic [15:0]                 out_id,
	output logic [spmq_pkg::LEVEL_W-1:0] out_level
);
	localparam int AW  = $clog2(DEPTH);
	localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int MAW = $clog2(LEVELS * DEPTH);

	logic [AW-1:0] head_q  [LEVELS];
	logic [CW-1:0] count_q [LEVELS];

	spmq_pkg::cmd_t        cmd_q;
	logic [ID_WIDTH-1:0]   id_q;
	logic [LW-1:0]         tgt_q;
	logic                  lvl_ok_q;
	logic [LW-1:0]         sl_q;     // level under search / pop
	logic [CW-1:0]         k_q;      // offset within level
	logic [spmq_pkg::STATUS_W-1:0] status_q;
	logic [ID_WIDTH-1:0]   oid_q;
	logic [spmq_pkg::LEVEL_W-1:0] olvl_q;

	logic                  we;
	logic [MAW-1:0]        waddr, raddr;
	logic [ID_WIDTH-1:0]   wdata, rdata;

	spmq_ram #(.WIDTH(ID_WIDTH), .DEPTH(LEVELS * DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	function automatic logic [MAW-1:0] slot(input logic [LW-1:0] lv,
			input logic [AW-1:0] hd, input logic [CW-1:0] off);
		logic [AW:0] s;
		logic [AW:0] wrapped;
		s = {1'b0, hd} + {1'b0, off[AW-1:0]};
		wrapped = (s >= (AW+1)'(DEPTH)) ? s - (AW+1)'(DEPTH) : s;
		return MAW'(lv) * MAW'(DEPTH) + MAW'(wrapped[AW-1:0]);
	endfunction

	// highest non-empty level
	logic [LW-1:0] top_lv;
	logic          any_ne;
	always_comb begin
		top_lv = '0;
		any_ne = 1'b0;
		for (int i = 0; i < LEVELS; i++)
			if (count_q[i] != '0) begin
				top_lv = LW'(i);
				any_ne = 1'b1;
			end
	end

	logic lvl_in_range;
	assign lvl_in_range = (in_level >= 3'd1) && (32'(in_level) <= LEVELS);

	// status toward controller
	always_comb begin
		st.cmd          = cmd_q;
		st.lvl_valid    = lvl_ok_q;
		st.tgt_full     = count_q[tgt_q] == CW'(DEPTH);
		st.any_nonempty = any_ne;
		st.match        = rdata == id_q;
		st.srch_skip    = k_q >= count_q[sl_q];
		st.srch_end     = (32'(sl_q) == LEVELS - 1) && (k_q >= count_q[sl_q])
			&& !(k_q < count_q[sl_q]);
		st.shift_last   = (k_q + CW'(1)) >= count_q[sl_q];
		st.shift_tail   = ({1'b0, k_q} + (CW+1)'(2)) >= {1'b0, count_q[sl_q]};
		st.out_ready    = 1'b0;
	end

	// store addressing
	always_comb begin
		we    = 1'b0;
		wdata = id_q;
		waddr = slot(tgt_q, head_q[tgt_q], count_q[tgt_q]);
		raddr = slot(sl_q, head_q[sl_q], k_q);
		if (ct.shift_rd) raddr = slot(sl_q, head_q[sl_q], k_q + CW'(1));
		if (ct.append) we = 1'b1;
		if (ct.shift_wr) begin
			we    = 1'b1;
			waddr = slot(sl_q, head_q[sl_q], k_q);
			wdata = rdata;
		end
	end

	// control and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			cmd_q    <= spmq_pkg::CMD_NOP;
			lvl_ok_q <= 1'b0;
			tgt_q    <= '0;
			sl_q     <= '0;
			k_q      <= '0;
			status_q <= '0;
			oid_q    <= '0;
			olvl_q   <= '0;
			id_q     <= '0;
		end else begin
			if (ct.latch_in) begin
				cmd_q    <= spmq_pkg::cmd_t'(in_command);
				id_q     <= ID_WIDTH'(in_entry_id);
				lvl_ok_q <= lvl_in_range;
				tgt_q    <= lvl_in_range ? LW'(in_level - 3'd1) : '0;
				oid_q    <= '0;
				olvl_q   <= '0;
			end
			if (ct.set_status) status_q <= ct.status;
			if (ct.pop_sel) begin
				sl_q <= top_lv;
				k_q  <= '0;
			end
			if (ct.pop_done) begin
				oid_q  <= rdata;
				olvl_q <= spmq_pkg::LEVEL_W'(sl_q) + 3'd1;
				head_q[sl_q]  <= (32'(head_q[sl_q]) == DEPTH - 1) ? '0
					: head_q[sl_q] + AW'(1);
				count_q[sl_q] <= count_q[sl_q] - CW'(1);
			end
			if (ct.srch_start) begin
				sl_q <= '0;
				k_q  <= '0;
			end
			// skip past an exhausted level without reading
			if (ct.srch_rd && k_q >= count_q[sl_q]) begin
				sl_q <= sl_q + LW'(1);
				k_q  <= '0;
			end
			if (ct.srch_step && k_q < count_q[sl_q]) k_q <= k_q + CW'(1);
			if (ct.shift_wr) k_q <= k_q + CW'(1);
			if (ct.shift_done) count_q[sl_q] <= count_q[sl_q] - CW'(1);
			if (ct.append) count_q[tgt_q] <= count_q[tgt_q] + CW'(1);
		end
	end

	assign status    = status_q;
	assign out_id    = 16'(oid_q);
	assign out_level = olvl_q;
endmodule
